@@ rtl/tlssni_pkg.sv @@
package tlssni_pkg;

  // Status codes carried by the final word of a record.
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_SHORT       = 4'd1;
  localparam logic [3:0] ST_BAD_TYPE    = 4'd2;
  localparam logic [3:0] ST_REC_VERSION = 4'd3;
  localparam logic [3:0] ST_NOT_HELLO   = 4'd4;
  localparam logic [3:0] ST_HS_LENGTH   = 4'd5;
  localparam logic [3:0] ST_HS_VERSION  = 4'd6;
  localparam logic [3:0] ST_OVERFLOW    = 4'd7;
  localparam logic [3:0] ST_NO_NAME     = 4'd8;
  localparam logic [3:0] ST_MISMATCH    = 4'd9;

  localparam logic [23:0] CT_HANDSHAKE    = 24'h000016;
  localparam logic [23:0] HS_CLIENT_HELLO = 24'h000001;
  localparam logic [23:0] VER_TLS10       = 24'h000301;
  localparam logic [23:0] VER_TLS11       = 24'h000302;
  localparam logic [23:0] VER_TLS12       = 24'h000303;
  localparam logic [16:0] SHORT_LIMIT     = 17'd43;
  localparam logic [16:0] POS_MAX         = 17'h1FFFF;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  name_byte;
    logic [3:0]  status_code;
    logic [15:0] name_length;
    logic        end_of_record;
  } res_t;

  // Words handed from the parser to the output queue in one cycle.
  typedef struct packed {
    logic push_a;
    logic push_b;
  } push_t;

endpackage

@@ rtl/tlssni_parse.sv @@
module tlssni_parse import tlssni_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       room_i,
  output push_t      push_o,
  output res_t       res_a_o,
  output res_t       res_b_o
);

  typedef enum logic [4:0] {
    PH_TYPE, PH_RVER, PH_RLEN, PH_HTYPE, PH_HLEN, PH_HVER, PH_RANDOM,
    PH_SESSLEN, PH_SESS, PH_CIPHLEN, PH_CIPH, PH_COMPLEN, PH_COMP,
    PH_EXTSLEN, PH_EXTTYPE, PH_EXTLEN, PH_SNILIST, PH_SNILEN, PH_NAME,
    PH_EXTSKIP, PH_DONE
  } phase_e;

  typedef struct packed {
    phase_e      ph;
    logic        go;
    logic [15:0] skip;
    logic [3:0]  fail;
  } nxt_t;

  function automatic nxt_t start(phase_e ph, logic [15:0] n);
    nxt_t r;
    r.ph = ph; r.go = 1'b1; r.skip = n; r.fail = ST_OK;
    return r;
  endfunction

  function automatic nxt_t stop(logic [3:0] code);
    nxt_t r;
    r.ph = PH_DONE; r.go = 1'b0; r.skip = '0; r.fail = code;
    return r;
  endfunction

  function automatic nxt_t loop_top(logic rem_le4);
    nxt_t r;
    if (rem_le4) r = stop(ST_OK);
    else         r = start(PH_EXTTYPE, 16'd2);
    return r;
  endfunction

  function automatic nxt_t skip_done(phase_e ph, logic rem_lt2, logic rem_le4);
    nxt_t r;
    unique case (ph)
      PH_RANDOM:  r = start(PH_SESSLEN, 16'd1);
      PH_SESS:    r = rem_lt2 ? stop(ST_OVERFLOW) : start(PH_CIPHLEN, 16'd2);
      PH_CIPH:    r = start(PH_COMPLEN, 16'd1);
      PH_COMP:    r = rem_lt2 ? stop(ST_OVERFLOW) : start(PH_EXTSLEN, 16'd2);
      PH_EXTSKIP: r = loop_top(rem_le4);
      default:    r = stop(ST_OK);
    endcase
    return r;
  endfunction

  function automatic nxt_t start_skip(phase_e ph, logic [23:0] n, logic rem_lt2,
                                      logic rem_le4);
    nxt_t r;
    if (n == '0) r = skip_done(ph, rem_lt2, rem_le4);
    else         r = start(ph, n[15:0]);
    return r;
  endfunction

  function automatic logic good_version(logic [23:0] v);
    return (v == VER_TLS10) || (v == VER_TLS11) || (v == VER_TLS12);
  endfunction

  logic        in_valid_q, in_last_q;
  logic [7:0]  in_byte_q;
  logic        advance;

  phase_e      ph_q, ph_d;
  logic [16:0] pos_q, pos_d;
  logic [15:0] rec_q, rec_d;
  logic [23:0] acc_q, acc_d;
  logic [15:0] skip_q, skip_d;
  logic [15:0] ext_q, ext_d;
  logic [15:0] found_q, found_d;
  logic        name_found_q, name_found_d;
  logic [3:0]  err_q, err_d;

  logic [23:0]        acc_n;
  logic signed [24:0] rem, v_s;
  logic               rem_lt2, rem_le4;
  logic [15:0]        skip_dec;
  logic               emit_name;
  logic [3:0]         st;
  nxt_t               nx;
  res_t               name_res, stat_res;

  assign advance    = in_valid_q && room_i;
  assign in_ready_o = !in_valid_q || room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

  always_comb begin
    pos_d    = (pos_q == POS_MAX) ? pos_q : pos_q + 17'd1;
    acc_n    = {acc_q[15:0], in_byte_q};
    rem      = $signed({8'b0, rec_q, 1'b0} >> 1) + 25'sd5 - $signed({8'b0, pos_d});
    v_s      = $signed({1'b0, acc_n});
    rem_lt2  = rem < 25'sd2;
    rem_le4  = rem <= 25'sd4;
    skip_dec = (skip_q == '0) ? '0 : skip_q - 16'd1;

    ph_d         = ph_q;
    acc_d        = acc_q;
    skip_d       = skip_q;
    rec_d        = rec_q;
    ext_d        = ext_q;
    found_d      = found_q;
    name_found_d = name_found_q;
    err_d        = err_q;
    emit_name    = 1'b0;
    nx           = stop(ST_OK);

    if (ph_q != PH_DONE) begin
      emit_name = (ph_q == PH_NAME);
      acc_d     = acc_n;
      skip_d    = skip_dec;
      if (skip_dec == '0) begin
        unique case (ph_q)
          PH_TYPE:
            nx = (acc_n != CT_HANDSHAKE) ? stop(ST_BAD_TYPE) : start(PH_RVER, 16'd2);
          PH_RVER:
            nx = !good_version(acc_n) ? stop(ST_REC_VERSION) : start(PH_RLEN, 16'd2);
          PH_RLEN: begin
            rec_d = acc_n[15:0];
            nx    = start(PH_HTYPE, 16'd1);
          end
          PH_HTYPE:
            nx = (acc_n != HS_CLIENT_HELLO) ? stop(ST_NOT_HELLO) : start(PH_HLEN, 16'd3);
          PH_HLEN:
            nx = (({1'b0, acc_n} + 25'd4) != {9'b0, rec_q}) ? stop(ST_HS_LENGTH)
                                                            : start(PH_HVER, 16'd2);
          PH_HVER:
            nx = !good_version(acc_n) ? stop(ST_HS_VERSION) : start(PH_RANDOM, 16'd32);
          PH_SESSLEN:
            nx = (v_s >= rem) ? stop(ST_OVERFLOW)
                              : start_skip(PH_SESS, acc_n, rem_lt2, rem_le4);
          PH_CIPHLEN:
            nx = (v_s >= rem) ? stop(ST_OVERFLOW)
                              : start_skip(PH_CIPH, acc_n, rem_lt2, rem_le4);
          PH_COMPLEN:
            nx = (v_s >= rem) ? stop(ST_OVERFLOW)
                              : start_skip(PH_COMP, acc_n, rem_lt2, rem_le4);
          PH_EXTSLEN:
            nx = (v_s > rem) ? stop(ST_OVERFLOW) : loop_top(rem_le4);
          PH_EXTTYPE: begin
            ext_d = acc_n[15:0];
            nx    = start(PH_EXTLEN, 16'd2);
          end
          PH_EXTLEN: begin
            if (v_s > rem) begin
              nx = stop(ST_OVERFLOW);
            end else if (ext_q == '0) begin
              if (acc_n < 24'd5) begin
                nx = stop(ST_OVERFLOW);
              end else begin
                // Upper bound for the host name length inside this extension.
                found_d = acc_n[15:0] - 16'd5;
                nx      = start(PH_SNILIST, 16'd3);
              end
            end else begin
              nx = start_skip(PH_EXTSKIP, acc_n, rem_lt2, rem_le4);
            end
          end
          PH_SNILIST:
            nx = start(PH_SNILEN, 16'd2);
          PH_SNILEN: begin
            if (acc_n > {8'b0, found_q}) begin
              nx = stop(ST_OVERFLOW);
            end else begin
              found_d      = acc_n[15:0];
              name_found_d = 1'b1;
              nx = (acc_n == '0) ? stop(ST_OK) : start(PH_NAME, acc_n[15:0]);
            end
          end
          default:
            nx = skip_done(ph_q, rem_lt2, rem_le4);
        endcase
        ph_d = nx.ph;
        if (nx.go) begin
          skip_d = nx.skip;
          acc_d  = '0;
        end
        if (nx.fail != ST_OK && err_q == ST_OK) begin
          err_d = nx.fail;
        end
      end
    end

    if (pos_d <= SHORT_LIMIT) begin
      st = ST_SHORT;
    end else if (err_d == ST_BAD_TYPE || err_d == ST_REC_VERSION) begin
      st = err_d;
    end else if (pos_d != ({1'b0, rec_d} + 17'd5)) begin
      st = ST_MISMATCH;
    end else if (err_d != ST_OK) begin
      st = err_d;
    end else if (name_found_d) begin
      st = ST_OK;
    end else begin
      st = ST_NO_NAME;
    end

    name_res.item_kind     = 1'b0;
    name_res.name_byte     = in_byte_q;
    name_res.status_code   = ST_OK;
    name_res.name_length   = '0;
    name_res.end_of_record = 1'b0;

    stat_res.item_kind     = 1'b1;
    stat_res.name_byte     = '0;
    stat_res.status_code   = st;
    stat_res.name_length   = (st == ST_OK) ? found_d : '0;
    stat_res.end_of_record = 1'b1;

    res_a_o       = emit_name ? name_res : stat_res;
    res_b_o       = stat_res;
    push_o.push_a = advance && (emit_name || in_last_q);
    push_o.push_b = advance && emit_name && in_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q         <= PH_TYPE;
      pos_q        <= '0;
      rec_q        <= '0;
      acc_q        <= '0;
      skip_q       <= 16'd1;
      ext_q        <= '0;
      found_q      <= '0;
      name_found_q <= 1'b0;
      err_q        <= ST_OK;
    end else if (advance) begin
      if (in_last_q) begin
        // The record is closed; start over for the next one.
        ph_q         <= PH_TYPE;
        pos_q        <= '0;
        rec_q        <= '0;
        acc_q        <= '0;
        skip_q       <= 16'd1;
        ext_q        <= '0;
        found_q      <= '0;
        name_found_q <= 1'b0;
        err_q        <= ST_OK;
      end else begin
        ph_q         <= ph_d;
        pos_q        <= pos_d;
        rec_q        <= rec_d;
        acc_q        <= acc_d;
        skip_q       <= skip_d;
        ext_q        <= ext_d;
        found_q      <= found_d;
        name_found_q <= name_found_d;
        err_q        <= err_d;
      end
    end
  end

endmodule

@@ rtl/tlssni_ofifo.sv @@
module tlssni_ofifo import tlssni_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  input  res_t  res_a_i,
  input  res_t  res_b_i,
  output logic  room_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  out_res_o
);

  localparam logic [QAw:0] Depth = (QAw + 1)'(QDepth);

  res_t           mem_q [QDepth];
  logic [QAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAw:0]   count_q;
  logic           pop;
  logic [QAw:0]   n_push;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_res_o   = mem_q[rd_ptr_q];
  // Leave space for the two words a single byte can produce.
  assign room_o      = count_q <= (Depth - (QAw + 1)'(2));
  assign n_push      = (QAw + 1)'(push_i.push_a) + (QAw + 1)'(push_i.push_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + n_push[QAw-1:0];
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + n_push - (QAw + 1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push_a) begin
      mem_q[wr_ptr_q] <= res_a_i;
    end
    if (push_i.push_b) begin
      mem_q[wr_ptr_q + 1'b1] <= res_b_i;
    end
  end

endmodule

@@ rtl/tls_client_hello_sni_extractor_core.sv @@
// Server name extraction from a TLS ClientHello record.
// The slave channel takes the record one byte per word, tlast on its final
// byte. The master channel returns the name bytes of the first server-name
// extension as they pass (tuser 0), then one status word on the final byte
// (tuser 1, tlast 1) with a status code and the name length. A non-zero
// status means the name bytes already sent must be discarded.
// An accepted byte passes through the input register, then the parser writes
// its word into the output queue. One byte is taken per cycle while the
// output queue has room; the last byte of a record ending in a name byte
// yields two words, and the four-entry output queue absorbs that.
// When the receiver stalls, the queue fills and tready drops once fewer than
// two entries are free; no word is lost or repeated.
// Reset clears the parser to expect a new record and empties the queue.
module tls_client_hello_sni_extractor_core import tlssni_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [7:0] name_byte, [11:8] status_code,
                                     // [27:12] name_length, [31:28] zero
  output logic        m_axis_tuser,  // item_kind
  output logic        m_axis_tlast
);

  push_t push;
  res_t  res_a, res_b, out_res;
  logic  room;

  tlssni_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .room_i     (room),
    .push_o     (push),
    .res_a_o    (res_a),
    .res_b_o    (res_b)
  );

  tlssni_ofifo u_ofifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_a_i     (res_a),
    .res_b_i     (res_b),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res)
  );

  assign m_axis_tdata = {4'b0, out_res.name_length, out_res.status_code, out_res.name_byte};
  assign m_axis_tuser = out_res.item_kind;
  assign m_axis_tlast = out_res.end_of_record;

endmodule
